// File: hdl/ssrc_pkg.sv
// shared types, constants and codes of the session sequence replay check
`default_nettype none
package ssrc_pkg;

  localparam int RETIRED_DEPTH = 8;
  localparam int RETIRED_AW    = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
  localparam int FILL_W        = $clog2(RETIRED_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDRESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_PORT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SENDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORWARD_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_AFTER_MS  = 3'd4;

  localparam logic [30:0] GAP_RESET   = 31'd1024;
  localparam logic [31:0] STALE_RESET = 32'd1000;
  localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;

  localparam logic [1:0] FUNC_CHECK = 2'd0;
  localparam logic [1:0] FUNC_STALE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] DEC_ACCEPTED  = 3'd0;
  localparam logic [2:0] DEC_SOURCE    = 3'd1;
  localparam logic [2:0] DEC_SENDER    = 3'd2;
  localparam logic [2:0] DEC_RETIRED   = 3'd3;
  localparam logic [2:0] DEC_REPLAY    = 3'd4;
  localparam logic [2:0] DEC_REORDERED = 3'd5;
  localparam logic [2:0] DEC_GAP       = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [63:0] frame_sender;
    logic [63:0] frame_epoch;
    logic [31:0] sequence_req;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] decision;
    logic       is_stale;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       dec_load;
    logic [2:0] dec_val;
    logic       stale_load;
    logic       adopt_epoch;
    logic       push_epoch;
    logic       seq_commit;
    logic       clear_sess;
    logic       scan_clear;
    logic       scan_inc;
    logic       load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       src_ok;
    logic       snd_ok;
    logic       epoch_known;
    logic       epoch_same;
    logic       scan_done;
    logic       hist_hit;
    logic [2:0] seq_dec;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/ssrc_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ssrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/ssrc_datapath.sv
// datapath: config registers, session state, retired epoch history, result registers
`default_nettype none
module ssrc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ssrc_pkg::in_item_t                  in_data,
  input  wire logic                                cfg_we,
  input  wire logic [ssrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ssrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire ssrc_pkg::dp_cmd_t                   cmd,
  output ssrc_pkg::dp_status_t                     status,
  output ssrc_pkg::out_item_t                      out_data
);

  localparam int AW = ssrc_pkg::RETIRED_AW;
  localparam int FW = ssrc_pkg::FILL_W;

  // configuration
  logic [31:0] peer_addr_r;
  logic [15:0] peer_port_r;
  logic [63:0] exp_sender_r;
  logic [30:0] max_gap_r;
  logic [31:0] stale_after_r;

  // session state
  ssrc_pkg::in_item_t in_r;
  logic [63:0]        cur_epoch_r, cur_epoch_nxt;
  logic               epoch_known_r, epoch_known_nxt;
  logic               seq_known_r, seq_known_nxt;
  logic [31:0]        last_seq_r, last_seq_nxt;
  logic [31:0]        last_time_r, last_time_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [FW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [2:0]         dec_r, dec_nxt;
  logic               stale_r, stale_nxt;
  ssrc_pkg::out_item_t out_r;

  logic [63:0]   hist_rdata;
  logic [AW-1:0] hist_waddr;
  logic          hist_full;
  logic          snd_ok;
  logic          snd_done;
  logic [7:0]    byte_a, byte_b;
  logic [31:0]   delta;
  logic [31:0]   age;
  logic [2:0]    seq_dec;
  logic          stale_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_addr_r   <= '0;
      peer_port_r   <= '0;
      exp_sender_r  <= '0;
      max_gap_r     <= ssrc_pkg::GAP_RESET;
      stale_after_r <= ssrc_pkg::STALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ssrc_pkg::CFG_PEER_ADDRESS:    peer_addr_r   <= cfg_data[31:0];
        ssrc_pkg::CFG_PEER_PORT:       peer_port_r   <= cfg_data[15:0];
        ssrc_pkg::CFG_EXPECTED_SENDER: exp_sender_r  <= cfg_data;
        ssrc_pkg::CFG_MAX_FORWARD_GAP: max_gap_r     <= cfg_data[30:0];
        ssrc_pkg::CFG_STALE_AFTER_MS:  stale_after_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sender id compare, stops at the first byte that differs or that is zero in both
  always_comb begin
    snd_ok   = 1'b1;
    snd_done = 1'b0;
    byte_a   = '0;
    byte_b   = '0;
    for (int i = 0; i < 8; i++) begin
      byte_a = in_r.frame_sender[8*i +: 8];
      byte_b = exp_sender_r[8*i +: 8];
      if (!snd_done) begin
        if (byte_a != byte_b) begin
          snd_ok   = 1'b0;
          snd_done = 1'b1;
        end else if (byte_a == 8'd0) begin
          snd_done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    delta = in_r.sequence_req - last_seq_r;
    if (!seq_known_r) begin
      seq_dec = ssrc_pkg::DEC_ACCEPTED;
    end else if (delta == 32'd0) begin
      seq_dec = ssrc_pkg::DEC_REPLAY;
    end else if (delta >= ssrc_pkg::HALF_RANGE) begin
      seq_dec = ssrc_pkg::DEC_REORDERED;
    end else if (delta[30:0] > max_gap_r) begin
      seq_dec = ssrc_pkg::DEC_GAP;
    end else begin
      seq_dec = ssrc_pkg::DEC_ACCEPTED;
    end
    age       = in_r.time_ms - last_time_r;
    stale_now = !seq_known_r || (age > stale_after_r);
  end

  assign hist_full  = (fill_r == FW'(ssrc_pkg::RETIRED_DEPTH));
  assign hist_waddr = hist_full ? head_r : fill_r[AW-1:0];

  // history kept as a ring: once full, the oldest entry sits at head
  ssrc_ram #(
    .WIDTH (64),
    .DEPTH (ssrc_pkg::RETIRED_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.push_epoch),
    .waddr (hist_waddr),
    .wdata (cur_epoch_r),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (hist_rdata)
  );

  always_comb begin
    cur_epoch_nxt   = cur_epoch_r;
    epoch_known_nxt = epoch_known_r;
    seq_known_nxt   = seq_known_r;
    last_seq_nxt    = last_seq_r;
    last_time_nxt   = last_time_r;
    fill_nxt        = fill_r;
    head_nxt        = head_r;
    scan_idx_nxt    = scan_idx_r;
    dec_nxt         = dec_r;
    stale_nxt       = stale_r;

    if (cmd.latch_in) begin
      dec_nxt   = ssrc_pkg::DEC_ACCEPTED;
      stale_nxt = 1'b0;
    end
    if (cmd.dec_load) begin
      dec_nxt = cmd.dec_val;
    end
    if (cmd.stale_load) begin
      stale_nxt = stale_now;
    end
    if (cmd.adopt_epoch) begin
      cur_epoch_nxt   = in_r.frame_epoch;
      epoch_known_nxt = 1'b1;
      seq_known_nxt   = 1'b0;
    end
    if (cmd.push_epoch) begin
      cur_epoch_nxt = in_r.frame_epoch;
      seq_known_nxt = 1'b0;
      if (!hist_full) begin
        fill_nxt = fill_r + FW'(1);
      end else if (head_r == AW'(ssrc_pkg::RETIRED_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + AW'(1);
      end
    end
    if (cmd.seq_commit) begin
      last_seq_nxt  = in_r.sequence_req;
      last_time_nxt = in_r.time_ms;
      seq_known_nxt = 1'b1;
    end
    if (cmd.scan_clear) begin
      scan_idx_nxt = '0;
    end else if (cmd.scan_inc) begin
      scan_idx_nxt = scan_idx_r + FW'(1);
    end
    if (cmd.clear_sess) begin
      cur_epoch_nxt   = '0;
      epoch_known_nxt = 1'b0;
      seq_known_nxt   = 1'b0;
      last_seq_nxt    = '0;
      last_time_nxt   = '0;
      fill_nxt        = '0;
      head_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_epoch_r   <= '0;
      epoch_known_r <= 1'b0;
      seq_known_r   <= 1'b0;
      last_seq_r    <= '0;
      last_time_r   <= '0;
      fill_r        <= '0;
      head_r        <= '0;
      scan_idx_r    <= '0;
    end else begin
      cur_epoch_r   <= cur_epoch_nxt;
      epoch_known_r <= epoch_known_nxt;
      seq_known_r   <= seq_known_nxt;
      last_seq_r    <= last_seq_nxt;
      last_time_r   <= last_time_nxt;
      fill_r        <= fill_nxt;
      head_r        <= head_nxt;
      scan_idx_r    <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
    dec_r   <= dec_nxt;
    stale_r <= stale_nxt;
    if (cmd.load_out) begin
      out_r.decision <= dec_r;
      out_r.is_stale <= stale_r;
    end
  end

  assign status.func        = in_r.func;
  assign status.src_ok      = (in_r.source_address == peer_addr_r) &&
                              (in_r.source_port == peer_port_r);
  assign status.snd_ok      = snd_ok;
  assign status.epoch_known = epoch_known_r;
  assign status.epoch_same  = (in_r.frame_epoch == cur_epoch_r);
  assign status.scan_done   = (scan_idx_r >= fill_r);
  assign status.hist_hit    = (hist_rdata == in_r.frame_epoch);
  assign status.seq_dec     = seq_dec;

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: hdl/ssrc_ctrl.sv
// controller: sequences one item through the datapath and owns both handshakes
`default_nettype none
module ssrc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ssrc_pkg::dp_status_t status,
  output ssrc_pkg::dp_cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EXEC     = 6'b000010,
    ST_SCAN_RD  = 6'b000100,
    ST_SCAN_CMP = 6'b001000,
    ST_SEQ      = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (status.func)
          ssrc_pkg::FUNC_CHECK: begin
            if (!status.src_ok) begin
              cmd.dec_load = 1'b1;
              cmd.dec_val  = ssrc_pkg::DEC_SOURCE;
            end else if (!status.snd_ok) begin
              cmd.dec_load = 1'b1;
              cmd.dec_val  = ssrc_pkg::DEC_SENDER;
            end else if (!status.epoch_known) begin
              cmd.adopt_epoch = 1'b1;
              state_nxt       = ST_SEQ;
            end else if (!status.epoch_same) begin
              cmd.scan_clear = 1'b1;
              state_nxt      = ST_SCAN_RD;
            end else begin
              state_nxt = ST_SEQ;
            end
          end
          ssrc_pkg::FUNC_STALE: cmd.stale_load = 1'b1;
          ssrc_pkg::FUNC_CLEAR: cmd.clear_sess = 1'b1;
          default: ;
        endcase
      end
      ST_SCAN_RD: begin
        // history entry at the scan index is read on this edge
        if (status.scan_done) begin
          cmd.push_epoch = 1'b1;
          state_nxt      = ST_SEQ;
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (status.hist_hit) begin
          cmd.dec_load = 1'b1;
          cmd.dec_val  = ssrc_pkg::DEC_RETIRED;
          state_nxt    = ST_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_SCAN_RD;
        end
      end
      ST_SEQ: begin
        cmd.dec_load   = 1'b1;
        cmd.dec_val    = status.seq_dec;
        cmd.seq_commit = (status.seq_dec == ssrc_pkg::DEC_ACCEPTED);
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: hdl/session_sequence_replay_check.sv
// a stale query, a clear, an unused code or a source or sender mismatch goes from exec
// straight to done; a frame with no epoch change passes through the sequence check; an epoch
// change first scans each retired epoch held (ram read and compare), then, if none matches,
// the sequence check; one item at a time, the next item is taken while a result waits
// reset: synchronous active low; session state and config return to defaults, the history
// ram is not cleared and only entries below the fill count are ever compared
`default_nettype none
module session_sequence_replay_check (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ssrc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ssrc_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ssrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ssrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ssrc_pkg::dp_cmd_t    cmd;
  ssrc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ssrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ssrc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: sim/tb_session_sequence_replay_check.sv
// self-checking testbench: directed and random frames, stale queries and clears
`timescale 1ns / 100ps
`default_nettype none
module tb_session_sequence_replay_check;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned PRINT_CAP   = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  ssrc_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  ssrc_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ssrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  session_sequence_replay_check u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies as the block should hold them
  logic [31:0] m_peer_addr = '0;
  logic [15:0] m_peer_port = '0;
  logic [63:0] m_sender    = '0;
  logic [30:0] m_gap       = ssrc_pkg::GAP_RESET;
  logic [31:0] m_stale     = ssrc_pkg::STALE_RESET;

  // session state of the predictor
  logic [63:0] s_epoch       = '0;
  logic        s_epoch_known = 1'b0;
  logic        s_seq_known   = 1'b0;
  logic [31:0] s_last_seq    = '0;
  logic [31:0] s_last_time   = '0;
  logic [63:0] s_hist [ssrc_pkg::RETIRED_DEPTH];
  int unsigned s_fill        = 0;

  // generator's rough view of the peer
  logic [63:0] g_epoch = 64'h0123_4567_89AB_CDEF;
  logic [31:0] g_seq   = '0;
  logic [31:0] g_time  = '0;
  logic [63:0] g_retired [$];

  ssrc_pkg::in_item_t  req_q [$];
  ssrc_pkg::out_item_t verdict_q [$];
  ssrc_pkg::out_item_t mon_want;

  bit          hold_sender    = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_accepted     = 0;
  int unsigned n_results      = 0;
  int unsigned n_errors       = 0;
  int unsigned n_stale        = 0;
  int unsigned n_cycles       = 0;
  int unsigned dec_seen [8];

  function automatic ssrc_pkg::out_item_t predict_verdict(ssrc_pkg::in_item_t it);
    ssrc_pkg::out_item_t v;
    logic [31:0] delta;
    logic        hit;
    logic        snd_ok;
    logic        done;
    v = '0;
    hit = 1'b0;
    snd_ok = 1'b1;
    done = 1'b0;
    case (it.func)
      ssrc_pkg::FUNC_CHECK: begin
        for (int i = 0; i < 8; i++) begin
          if (!done) begin
            if (it.frame_sender[8*i +: 8] != m_sender[8*i +: 8]) begin
              snd_ok = 1'b0;
              done = 1'b1;
            end else if (m_sender[8*i +: 8] == 8'd0) begin
              done = 1'b1;
            end
          end
        end
        if (it.source_address != m_peer_addr || it.source_port != m_peer_port) begin
          v.decision = ssrc_pkg::DEC_SOURCE;
        end else if (!snd_ok) begin
          v.decision = ssrc_pkg::DEC_SENDER;
        end else begin
          if (!s_epoch_known) begin
            s_epoch = it.frame_epoch;
            s_epoch_known = 1'b1;
            s_seq_known = 1'b0;
          end else if (it.frame_epoch != s_epoch) begin
            for (int i = 0; i < s_fill; i++) begin
              if (s_hist[i] == it.frame_epoch) hit = 1'b1;
            end
            if (hit) begin
              v.decision = ssrc_pkg::DEC_RETIRED;
            end else begin
              // full history drops its oldest epoch
              if (s_fill < ssrc_pkg::RETIRED_DEPTH) begin
                s_hist[s_fill] = s_epoch;
                s_fill++;
              end else begin
                for (int i = 0; i < ssrc_pkg::RETIRED_DEPTH - 1; i++) s_hist[i] = s_hist[i+1];
                s_hist[ssrc_pkg::RETIRED_DEPTH-1] = s_epoch;
              end
              s_epoch = it.frame_epoch;
              s_seq_known = 1'b0;
            end
          end
          if (!hit) begin
            delta = it.sequence_req - s_last_seq;
            if (s_seq_known && delta == 32'd0) begin
              v.decision = ssrc_pkg::DEC_REPLAY;
            end else if (s_seq_known && delta >= ssrc_pkg::HALF_RANGE) begin
              v.decision = ssrc_pkg::DEC_REORDERED;
            end else if (s_seq_known && delta > {1'b0, m_gap}) begin
              v.decision = ssrc_pkg::DEC_GAP;
            end else begin
              s_last_seq = it.sequence_req;
              s_last_time = it.time_ms;
              s_seq_known = 1'b1;
            end
          end
        end
      end
      ssrc_pkg::FUNC_STALE: begin
        v.is_stale = !s_seq_known || ((it.time_ms - s_last_time) > m_stale);
      end
      ssrc_pkg::FUNC_CLEAR: begin
        s_epoch = '0;
        s_epoch_known = 1'b0;
        s_seq_known = 1'b0;
        s_last_seq = '0;
        s_last_time = '0;
        s_fill = 0;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic int unsigned first_nul(logic [63:0] id);
    for (int i = 0; i < 8; i++) begin
      if (id[8*i +: 8] == 8'd0) return i;
    end
    return 8;
  endfunction

  // matching id, sometimes with junk after the terminator
  function automatic logic [63:0] good_sender();
    logic [63:0] s;
    int unsigned k;
    s = m_sender;
    k = first_nul(m_sender);
    if ($urandom_range(1)) begin
      for (int i = k + 1; i < 8; i++) s[8*i +: 8] = 8'($urandom);
    end
    return s;
  endfunction

  // flip one bit at or before the terminator so the compare must fail
  function automatic logic [63:0] bad_sender();
    logic [63:0] s;
    int unsigned k;
    int unsigned pos;
    s = good_sender();
    k = first_nul(m_sender);
    if (k > 7) k = 7;
    pos = 8 * $urandom_range(0, k) + $urandom_range(7);
    s[pos] = ~s[pos];
    return s;
  endfunction

  function automatic ssrc_pkg::in_item_t random_bits();
    ssrc_pkg::in_item_t it;
    it.func = 2'($urandom);
    it.source_address = $urandom;
    it.source_port = 16'($urandom);
    it.frame_sender = {$urandom, $urandom};
    it.frame_epoch = {$urandom, $urandom};
    it.sequence_req = $urandom;
    it.time_ms = $urandom;
    return it;
  endfunction

  function automatic ssrc_pkg::in_item_t frame_at(logic [63:0] e, logic [31:0] sq,
                                                  logic [31:0] t);
    ssrc_pkg::in_item_t it;
    it.func = ssrc_pkg::FUNC_CHECK;
    it.source_address = m_peer_addr;
    it.source_port = m_peer_port;
    it.frame_sender = good_sender();
    it.frame_epoch = e;
    it.sequence_req = sq;
    it.time_ms = t;
    return it;
  endfunction

  function automatic ssrc_pkg::in_item_t query_at(logic [31:0] t);
    ssrc_pkg::in_item_t it;
    it = random_bits();
    it.func = ssrc_pkg::FUNC_STALE;
    it.time_ms = t;
    return it;
  endfunction

  function automatic ssrc_pkg::in_item_t gen_item();
    ssrc_pkg::in_item_t it;
    int unsigned r;
    int unsigned lim;
    int unsigned k;
    r = $urandom_range(99);
    it = frame_at(g_epoch, g_seq, g_time);
    if (r < 4) begin
      it = random_bits();
      it.func = ssrc_pkg::FUNC_CLEAR;
    end else if (r < 11) begin
      case ($urandom_range(3))
        0: it = query_at(g_time + m_stale);
        1: it = query_at(g_time + m_stale + 32'd1);
        2: it = query_at(g_time + $urandom_range(0, 200));
        default: it = query_at($urandom);
      endcase
    end else if (r < 13) begin
      it = random_bits();
      it.func = FUNC_UNUSED;
    end else if (r < 17) begin
      if ($urandom_range(1)) begin
        k = $urandom_range(31);
        it.source_address[k] = ~it.source_address[k];
      end else begin
        k = $urandom_range(15);
        it.source_port[k] = ~it.source_port[k];
      end
    end else if (r < 21) begin
      it.frame_sender = bad_sender();
    end else if (r < 27 || (r < 31 && g_retired.size() == 0)) begin
      g_retired.push_back(g_epoch);
      if (g_retired.size() > 16) void'(g_retired.pop_front());
      g_epoch = {$urandom, $urandom};
      if ($urandom_range(1)) g_seq = $urandom;
      g_time += $urandom_range(0, 60);
      it = frame_at(g_epoch, g_seq, g_time);
    end else if (r < 31) begin
      // pick one of the recently retired epochs
      lim = (g_retired.size() < 8) ? g_retired.size() : 8;
      k = g_retired.size() - 1 - $urandom_range(0, lim - 1);
      it.frame_epoch = g_retired[k];
    end else if (r < 37) begin
      it.time_ms = g_time + $urandom_range(0, 20);
    end else if (r < 43) begin
      if ($urandom_range(1)) it.sequence_req = g_seq - $urandom_range(1, 1000);
      else it.sequence_req = g_seq - ssrc_pkg::HALF_RANGE - $urandom_range(0, 1000);
    end else if (r < 49) begin
      it.sequence_req = g_seq + {1'b0, m_gap} + 32'd1 + $urandom_range(0, 100);
    end else begin
      lim = (m_gap == 0) ? 1 : ((m_gap > 256) ? 256 : m_gap);
      if (m_gap != 0 && $urandom_range(9) == 0) g_seq += {1'b0, m_gap};
      else g_seq += $urandom_range(1, lim);
      g_time += $urandom_range(0, 60);
      it = frame_at(g_epoch, g_seq, g_time);
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("result %0d: %s, expected %0d got %0d", n_results, what, want_v, got_v);
  endtask

  // sender: presents requests from req_q, predicts at each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(predict_verdict(in_data));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (!hold_sender && req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing pending, decision", 0, out_data.decision);
        end else begin
          mon_want = verdict_q.pop_front();
          if (out_data.decision !== mon_want.decision)
            report_mismatch("decision", mon_want.decision, out_data.decision);
          if (out_data.is_stale !== mon_want.is_stale)
            report_mismatch("is_stale", mon_want.is_stale, out_data.is_stale);
          dec_seen[mon_want.decision]++;
          if (mon_want.is_stale) n_stale++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles, verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [ssrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssrc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ssrc_pkg::CFG_PEER_ADDRESS:    m_peer_addr = val[31:0];
      ssrc_pkg::CFG_PEER_PORT:       m_peer_port = val[15:0];
      ssrc_pkg::CFG_EXPECTED_SENDER: m_sender = val;
      ssrc_pkg::CFG_MAX_FORWARD_GAP: m_gap = val[30:0];
      ssrc_pkg::CFG_STALE_AFTER_MS:  m_stale = val[31:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] addr, logic [15:0] port, logic [63:0] snd,
                            logic [30:0] gap, logic [31:0] stale);
    write_reg(ssrc_pkg::CFG_PEER_ADDRESS, {32'd0, addr});
    write_reg(ssrc_pkg::CFG_PEER_PORT, {48'd0, port});
    write_reg(ssrc_pkg::CFG_EXPECTED_SENDER, snd);
    write_reg(ssrc_pkg::CFG_MAX_FORWARD_GAP, {33'd0, gap});
    write_reg(ssrc_pkg::CFG_STALE_AFTER_MS, {32'd0, stale});
  endtask

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic load_directed();
    logic [63:0] e1;
    logic [63:0] e2;
    ssrc_pkg::in_item_t it;
    e1 = 64'h0123_4567_89AB_CDEF;
    e2 = '1;
    req_q.push_back(query_at(32'd0));
    it = '1;
    it.func = FUNC_UNUSED;
    req_q.push_back(it);
    it = frame_at(e1, 32'd1, 32'd50);
    it.source_address ^= 32'h1;
    req_q.push_back(it);
    it = frame_at(e1, 32'd1, 32'd50);
    it.source_port ^= 16'h8000;
    req_q.push_back(it);
    it = frame_at(e1, 32'd1, 32'd50);
    it.frame_sender = m_sender ^ 64'h0000_0000_0007_0000;
    req_q.push_back(it);
    // junk after the terminator must still match
    it = frame_at(e1, 32'hFFFF_FFFF, 32'd100);
    it.frame_sender = m_sender | 64'h5A5A_5A5A_0000_0000;
    req_q.push_back(it);
    req_q.push_back(frame_at(e1, 32'hFFFF_FFFF, 32'd110));
    req_q.push_back(frame_at(e1, 32'd0, 32'd150));
    req_q.push_back(frame_at(e1, ssrc_pkg::HALF_RANGE, 32'd155));
    req_q.push_back(frame_at(e1, {1'b0, m_gap}, 32'd160));
    req_q.push_back(frame_at(e1, {1'b0, m_gap} + {1'b0, m_gap} + 32'd1, 32'd170));
    req_q.push_back(query_at(32'd160 + m_stale));
    req_q.push_back(query_at(32'd161 + m_stale));
    req_q.push_back(frame_at(e2, 32'd5, 32'd300));
    req_q.push_back(frame_at(e1, 32'd6, 32'd310));
    req_q.push_back(frame_at('0, 32'd7, 32'd320));
    // overflow the history so the first epoch drops out
    for (int i = 1; i <= 7; i++) req_q.push_back(frame_at(64'h1000 + i, i, 32'd330 + i));
    req_q.push_back(frame_at(e1, 32'd20, 32'd400));
    req_q.push_back(frame_at(e2, 32'd21, 32'd410));
    it = '0;
    it.func = ssrc_pkg::FUNC_CLEAR;
    req_q.push_back(it);
    req_q.push_back(query_at(32'd500));
    req_q.push_back(frame_at(e2, 32'd22, 32'd510));
  endtask

  task automatic run_phase(int unsigned count, int unsigned idle_pct, int unsigned stall_pct,
                           bit pause_midway);
    int unsigned base;
    @(posedge clk);
    send_idle_pct <= idle_pct;
    recv_stall_pct <= stall_pct;
    g_time = $urandom;
    g_seq = $urandom;
    base = n_accepted;
    for (int i = 0; i < count; i++) req_q.push_back(gen_item());
    if (pause_midway) begin
      while (n_accepted < base + count / 2) @(posedge clk);
      hold_sender <= 1'b1;
      @(posedge clk);
      while (in_valid || verdict_q.size() != 0) @(posedge clk);
      repeat (10) @(posedge clk);
      hold_sender <= 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    logic [63:0] rnd_sender;
    int unsigned rnd_len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(32'hC0A8_0107, 16'd5000, 64'h0000_0000_0043_4241, 31'd16, 32'd100);
    load_directed();
    wait_drained();
    run_phase(300, 0, 0, 1'b0);

    set_config('1, '1, '1, 31'h7FFF_FFFF, '1);
    run_phase(300, 86, 0, 1'b0);

    set_config('0, '0, '0, '0, '0);
    run_phase(300, 0, 86, 1'b0);

    rnd_sender = '0;
    rnd_len = $urandom_range(0, 8);
    for (int i = 0; i < rnd_len; i++) rnd_sender[8*i +: 8] = 8'($urandom_range(1, 255));
    set_config($urandom, 16'($urandom), rnd_sender, 31'($urandom_range(1, 4096)),
               $urandom_range(0, 5000));
    run_phase(300, 24, 24, 1'b1);

    repeat (40) @(posedge clk);
    if (verdict_q.size() != 0) report_mismatch("results never delivered", verdict_q.size(), 0);
    $display("covered %0d transfers in, %0d out, over four register settings and four idle mixes",
             n_accepted, n_results);
    $display("accepted %0d source %0d sender %0d retired %0d",
             dec_seen[ssrc_pkg::DEC_ACCEPTED], dec_seen[ssrc_pkg::DEC_SOURCE],
             dec_seen[ssrc_pkg::DEC_SENDER], dec_seen[ssrc_pkg::DEC_RETIRED]);
    $display("replay %0d reordered %0d gap %0d stale %0d",
             dec_seen[ssrc_pkg::DEC_REPLAY], dec_seen[ssrc_pkg::DEC_REORDERED],
             dec_seen[ssrc_pkg::DEC_GAP], n_stale);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/ssrc_pkg.sv
hdl/ssrc_ram.sv
hdl/ssrc_datapath.sv
hdl/ssrc_ctrl.sv
hdl/session_sequence_replay_check.sv
sim/tb_session_sequence_replay_check.sv
